@@ design/pksl_pkg.sv @@
// Package for the keep-alive loss statistics block: sizes, word layouts.
`default_nettype none

package pksl_pkg;

   // Table depth and the width of a slot number
   localparam int NODE_SLOTS = 32;
   localparam int SLOT_W     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

   // Field widths
   localparam int MAC_W      = 48;
   localparam int SEQ_W      = 32;
   localparam int TIME_W     = 64;
   localparam int RSSI_W     = 8;
   localparam int LAYER_W    = 8;
   localparam int BYTES_W    = 16;
   localparam int CNT_W      = 64;
   localparam int SLOT_OUT_W = 5;

   // Stream word widths (rounded up to whole bytes)
   localparam int REQ_TDATA_W = 288;
   localparam int RSP_TDATA_W = 264;

   // Request word, first field in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [BYTES_W-1:0] byte_count;
      logic [MAC_W-1:0]   parent_address;
      logic [LAYER_W-1:0] mesh_layer;
      logic [RSSI_W-1:0]  signal_strength;
      logic [TIME_W-1:0]  far_timestamp_ms;
      logic [SEQ_W-1:0]   seq_num;
      logic [MAC_W-1:0]   source_mac;
   } req_word_type;

   // Response word, first field in the lowest bits, zero padded at the top
   typedef struct packed {
      logic [2:0]            pad;
      logic [CNT_W-1:0]      missed_total;
      logic [CNT_W-1:0]      bytes_total;
      logic [CNT_W-1:0]      message_total;
      logic [TIME_W-1:0]     first_seen_ms;
      logic [SLOT_OUT_W-1:0] slot_index;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ design/per_source_keepalive_loss_stats.sv @@
// Top level: per-source keep-alive sequence loss counters with a CAM-style slot table.
//
// Usage:
//  - req_* stream: one received keep-alive report per word (layout at the port).
//  - rsp_* stream: one result word per report; rsp_tuser is the table-full flag,
//    set when the source is new and every slot is taken (report dropped, data zero).
//  - The report sits in an input register; one pass of address compare over all
//    NODE_SLOTS slots, slot select, 64-bit counter adds and the slot write-back
//    runs between that register and the result register.
//  - The result register takes the held report's result when free or draining.
//  - Throughput: one report per cycle while not stalled; slot state is written back
//    at the edge that loads the result, so back-to-back reports to one source chain.
//  - When the receiver stalls, the result register holds its word and the input
//    register holds one more report; req_tready then falls until rsp_tready rises.
//  - Reset (synchronous) clears all slot valid marks and both pipeline valid flags;
//    slot contents are left as they are and are rebuilt on allocation.
`default_nettype none

module per_source_keepalive_loss_stats (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // source_mac, seq_num, far_timestamp_ms, signal_strength, mesh_layer,
   // parent_address, byte_count, now_ms (lowest bits first)
   input  wire logic [pksl_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // slot_index, first_seen_ms, message_total, bytes_total, missed_total,
   // 3 zero pad bits (lowest bits first)
   output logic [pksl_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // table_full
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready
);

   localparam int N  = pksl_pkg::NODE_SLOTS;
   localparam int SW = pksl_pkg::SLOT_W;

   // Pipeline registers
   pksl_pkg::req_word_type in_word_ff;
   logic                   in_valid_ff;
   pksl_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic                   rsp_valid_ff;

   // Slot table
   logic [N-1:0]                     slot_valid_ff;
   logic [pksl_pkg::MAC_W-1:0]       slot_address_ff    [N];
   logic [pksl_pkg::TIME_W-1:0]      first_time_ff      [N];
   logic [pksl_pkg::TIME_W-1:0]      last_local_time_ff [N];
   logic [pksl_pkg::TIME_W-1:0]      last_far_time_ff   [N];
   logic [pksl_pkg::CNT_W-1:0]       byte_sum_ff        [N];
   logic [pksl_pkg::CNT_W-1:0]       message_sum_ff     [N];
   logic [pksl_pkg::CNT_W-1:0]       missed_sum_ff      [N];
   logic [pksl_pkg::SEQ_W-1:0]       last_sequence_ff   [N];
   logic [pksl_pkg::MAC_W-1:0]       latest_parent_ff   [N];
   logic [pksl_pkg::LAYER_W-1:0]     latest_layer_ff    [N];
   logic [pksl_pkg::RSSI_W-1:0]      latest_strength_ff [N];

   // Update pass
   logic [N-1:0]                 match_vec, free_vec;
   logic [SW-1:0]                hit_slot, free_slot, sel_slot;
   logic                         hit_found, free_found, table_full, restart;
   logic                         advance, write_en;
   logic [pksl_pkg::CNT_W-1:0]   old_msg, old_bytes, old_missed;
   logic [pksl_pkg::TIME_W-1:0]  old_first;
   logic [pksl_pkg::SEQ_W-1:0]   old_seq;
   logic [pksl_pkg::CNT_W-1:0]   msg_in, bytes_in, missed_in;
   logic [pksl_pkg::TIME_W-1:0]  first_in;

   // Handshake: process the held word when the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign write_en   = advance && !table_full;

   // Address compare and free search over all slots, lowest number wins
   always_comb begin
      hit_slot  = '0;
      free_slot = '0;
      for (int s = 0; s < N; s++) begin
         match_vec[s] = slot_valid_ff[s] && (slot_address_ff[s] == in_word_ff.source_mac);
         free_vec[s]  = !slot_valid_ff[s];
      end
      for (int s = N - 1; s >= 0; s--) begin
         if (match_vec[s]) begin
            hit_slot = SW'(s);
         end
         if (free_vec[s]) begin
            free_slot = SW'(s);
         end
      end
      hit_found  = |match_vec;
      free_found = |free_vec;
      table_full = !hit_found && !free_found;
      sel_slot   = hit_found ? hit_slot : free_slot;
   end

   // Counter update: a new slot or index zero starts from zeros
   always_comb begin
      restart    = !hit_found || (in_word_ff.seq_num == '0);
      old_msg    = restart ? '0 : message_sum_ff[sel_slot];
      old_bytes  = restart ? '0 : byte_sum_ff[sel_slot];
      old_missed = restart ? '0 : missed_sum_ff[sel_slot];
      old_first  = restart ? '0 : first_time_ff[sel_slot];
      old_seq    = restart ? '0 : last_sequence_ff[sel_slot];
      msg_in     = old_msg + pksl_pkg::CNT_W'(1);
      bytes_in   = old_bytes + pksl_pkg::CNT_W'(in_word_ff.byte_count);
      first_in   = (old_msg == '0) ? in_word_ff.now_ms : old_first;
      if (in_word_ff.seq_num > old_seq) begin
         missed_in = old_missed + pksl_pkg::CNT_W'(in_word_ff.seq_num
                                                   - pksl_pkg::SEQ_W'(1) - old_seq);
      end else begin
         missed_in = old_missed;
      end
   end

   // Result word
   always_comb begin
      rsp_full_in = table_full;
      rsp_word_in = '0;
      if (!table_full) begin
         rsp_word_in.slot_index    = pksl_pkg::SLOT_OUT_W'(sel_slot);
         rsp_word_in.first_seen_ms = first_in;
         rsp_word_in.message_total = msg_in;
         rsp_word_in.bytes_total   = bytes_in;
         rsp_word_in.missed_total  = missed_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (write_en) begin
            slot_valid_ff[sel_slot] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= pksl_pkg::req_word_type'(req_tdata);
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   // Slot write-back
   always_ff @(posedge clock) begin
      if (write_en) begin
         slot_address_ff[sel_slot]    <= in_word_ff.source_mac;
         first_time_ff[sel_slot]      <= first_in;
         last_local_time_ff[sel_slot] <= in_word_ff.now_ms;
         last_far_time_ff[sel_slot]   <= in_word_ff.far_timestamp_ms;
         byte_sum_ff[sel_slot]        <= bytes_in;
         message_sum_ff[sel_slot]     <= msg_in;
         missed_sum_ff[sel_slot]      <= missed_in;
         last_sequence_ff[sel_slot]   <= in_word_ff.seq_num;
         latest_parent_ff[sel_slot]   <= in_word_ff.parent_address;
         latest_layer_ff[sel_slot]    <= in_word_ff.mesh_layer;
         latest_strength_ff[sel_slot] <= in_word_ff.signal_strength;
      end
   end

   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_full_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // Checks
   // a source never sits in two slots
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> $onehot0(match_vec))
      else $error("source address matches more than one slot");

   // a table-full result only when every slot is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (&slot_valid_ff))
      else $error("table full reported with a free slot");

   // a counted result points at a live slot
   assert property (@(posedge clock) disable iff (reset)
      (advance && !table_full) |=> slot_valid_ff[$past(sel_slot)])
      else $error("result slot not marked valid");

   // reset empties the table
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (slot_valid_ff == '0))
      else $error("slot valid marks not cleared by reset");

endmodule

`default_nettype wire

@@ tb/sv/keepalive_stats_checker.sv @@
// Checker for the keep-alive loss statistics block: predicts each result word and compares.
`timescale 1ns / 100ps

module keepalive_stats_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // source_mac, seq_num, far_timestamp_ms, signal_strength, mesh_layer,
   // parent_address, byte_count, now_ms (lowest bits first)
   input  wire logic [pksl_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   // slot_index, first_seen_ms, message_total, bytes_total, missed_total, pad
   input  wire logic [pksl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // table_full
   input  wire logic                             rsp_tuser,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output int                                    mismatch_count,
   output int                                    pending_count
);

   typedef struct packed {
      logic                            table_full;
      logic [pksl_pkg::SLOT_OUT_W-1:0] slot_index;
      logic [pksl_pkg::TIME_W-1:0]     first_seen;
      logic [pksl_pkg::CNT_W-1:0]      msg_total;
      logic [pksl_pkg::CNT_W-1:0]      byte_total;
      logic [pksl_pkg::CNT_W-1:0]      miss_total;
   } stats_result_type;

   // Shadow of the slot table; only what the result word depends on is kept
   logic                        occupied   [pksl_pkg::NODE_SLOTS];
   logic [pksl_pkg::MAC_W-1:0]  owner_mac  [pksl_pkg::NODE_SLOTS];
   logic [pksl_pkg::TIME_W-1:0] first_time [pksl_pkg::NODE_SLOTS];
   logic [pksl_pkg::CNT_W-1:0]  msg_count  [pksl_pkg::NODE_SLOTS];
   logic [pksl_pkg::CNT_W-1:0]  byte_count [pksl_pkg::NODE_SLOTS];
   logic [pksl_pkg::CNT_W-1:0]  miss_count [pksl_pkg::NODE_SLOTS];
   logic [pksl_pkg::SEQ_W-1:0]  last_seq   [pksl_pkg::NODE_SLOTS];

   stats_result_type       pending_stats[$];
   stats_result_type       want;
   pksl_pkg::rsp_word_type seen;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
      mismatch_count++;
   endtask

   // Update the shadow table with one report and return the counters it yields
   function automatic stats_result_type account_report(input pksl_pkg::req_word_type r);
      stats_result_type            res;
      int                          hit;
      int                          spare;
      logic [pksl_pkg::SEQ_W-1:0]  skipped;
      res   = '0;
      hit   = -1;
      spare = -1;
      for (int s = 0; s < pksl_pkg::NODE_SLOTS; s++) begin
         if (occupied[s]) begin
            if (hit < 0 && owner_mac[s] == r.source_mac) hit = s;
         end else if (spare < 0) begin
            spare = s;
         end
      end
      if (hit < 0) begin
         // new source with no room: dropped, data all zero
         if (spare < 0) begin
            res.table_full = 1'b1;
            return res;
         end
         hit = spare;
         occupied[hit]  = 1'b1;
         owner_mac[hit] = r.source_mac;
         msg_count[hit] = '0;
         byte_count[hit] = '0;
         miss_count[hit] = '0;
         last_seq[hit]  = '0;
         first_time[hit] = '0;
      end
      // index zero restarts the source
      if (r.seq_num == '0) begin
         msg_count[hit]  = '0;
         byte_count[hit] = '0;
         miss_count[hit] = '0;
         last_seq[hit]   = '0;
         first_time[hit] = '0;
      end
      if (msg_count[hit] == '0) first_time[hit] = r.now_ms;
      msg_count[hit]  = msg_count[hit] + pksl_pkg::CNT_W'(1);
      byte_count[hit] = byte_count[hit] + pksl_pkg::CNT_W'(r.byte_count);
      if (r.seq_num > last_seq[hit]) begin
         skipped = r.seq_num - pksl_pkg::SEQ_W'(1) - last_seq[hit];
         miss_count[hit] = miss_count[hit] + pksl_pkg::CNT_W'(skipped);
      end
      last_seq[hit] = r.seq_num;

      res.slot_index = pksl_pkg::SLOT_OUT_W'(hit);
      res.first_seen = first_time[hit];
      res.msg_total  = msg_count[hit];
      res.byte_total = byte_count[hit];
      res.miss_total = miss_count[hit];
      return res;
   endfunction

   // Results are retired before the new report is queued, so a word accepted
   // on the same edge can never satisfy its own expectation
   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < pksl_pkg::NODE_SLOTS; s++) occupied[s] = 1'b0;
         pending_stats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = pksl_pkg::rsp_word_type'(rsp_tdata);
            if (pending_stats.size() == 0) begin
               report_mismatch("result word with none pending", rsp_tdata[63:0], '0);
            end else begin
               want = pending_stats.pop_front();
               if (rsp_tuser !== want.table_full)
                  report_mismatch("table_full", 64'(rsp_tuser), 64'(want.table_full));
               if (seen.slot_index !== want.slot_index)
                  report_mismatch("slot_index", 64'(seen.slot_index), 64'(want.slot_index));
               if (seen.first_seen_ms !== want.first_seen)
                  report_mismatch("first_seen_ms", seen.first_seen_ms, want.first_seen);
               if (seen.message_total !== want.msg_total)
                  report_mismatch("message_total", seen.message_total, want.msg_total);
               if (seen.bytes_total !== want.byte_total)
                  report_mismatch("bytes_total", seen.bytes_total, want.byte_total);
               if (seen.missed_total !== want.miss_total)
                  report_mismatch("missed_total", seen.missed_total, want.miss_total);
               if (seen.pad !== '0)
                  report_mismatch("pad bits", 64'(seen.pad), '0);
            end
         end
         if (req_tvalid && req_tready)
            pending_stats.push_back(account_report(pksl_pkg::req_word_type'(req_tdata)));
      end
      pending_count = pending_stats.size();
   end

endmodule

@@ tb/sv/per_source_keepalive_loss_stats_tb.sv @@
// Testbench top for the keep-alive loss statistics block: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module per_source_keepalive_loss_stats_tb;

   localparam int POOL_SIZE  = 48;
   localparam int STALL_LIMIT = 2000;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic [pksl_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pksl_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;

   int mismatch_count;
   int pending_count;

   // idling controls and state
   logic source_idle_on = 1'b1;
   logic sink_idle_on   = 1'b1;
   int   sink_hold      = 0;
   int   quiet_cycles   = 0;

   // address pool and the next well-formed index of each source
   logic [pksl_pkg::MAC_W-1:0]  mac_pool [POOL_SIZE];
   logic [pksl_pkg::SEQ_W-1:0]  next_seq [POOL_SIZE];
   logic [pksl_pkg::TIME_W-1:0] local_ms = 64'd1000;

   per_source_keepalive_loss_stats uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   keepalive_stats_checker stats_check (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stall bursts while idling is on
   always @(negedge clock) begin
      if (reset || !sink_idle_on) begin
         rsp_tready <= 1'b1;
      end else if (sink_hold > 0) begin
         sink_hold  <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         sink_hold  <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles in which neither side moves a word
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("per_source_keepalive_loss_stats verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one report and hold it until accepted; optional gap beforehand
   task automatic send_report(input logic [pksl_pkg::MAC_W-1:0] mac,
                              input logic [pksl_pkg::SEQ_W-1:0] seq,
                              input logic [pksl_pkg::TIME_W-1:0] far_ms,
                              input logic [7:0] rssi, input logic [7:0] layer,
                              input logic [pksl_pkg::MAC_W-1:0] parent,
                              input logic [15:0] nbytes,
                              input logic [pksl_pkg::TIME_W-1:0] now);
      pksl_pkg::req_word_type w;
      int                     gap;
      w.source_mac       = mac;
      w.seq_num          = seq;
      w.far_timestamp_ms = far_ms;
      w.signal_strength  = rssi;
      w.mesh_layer       = layer;
      w.parent_address   = parent;
      w.byte_count       = nbytes;
      w.now_ms           = now;
      gap = (source_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait for every pending result
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [63:0]                 wide;
      logic [pksl_pkg::MAC_W-1:0]  mac;
      logic [pksl_pkg::SEQ_W-1:0]  seq;
      logic [pksl_pkg::TIME_W-1:0] now;
      int                          k;
      int                          pool_used;

      mac_pool[0] = '0;
      mac_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         wide = {$urandom, $urandom};
         mac_pool[i] = wide[pksl_pkg::MAC_W-1:0];
      end
      for (int i = 0; i < POOL_SIZE; i++) next_seq[i] = 32'd1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, skips, repeats, lower index, restart
      send_report(mac_pool[2], 32'd0, '1, 8'h80, 8'h00, '1, 16'hFFFF, '1);
      send_report(mac_pool[2], 32'd5, '0, 8'h7F, 8'hFF, '0, 16'hFFFF, 64'd10);
      send_report(mac_pool[2], 32'd5, 64'd7, 8'hFF, 8'h01, '0, 16'd0, 64'd11);
      send_report(mac_pool[2], 32'd3, 64'd8, 8'h00, 8'h80, '1, 16'd1, 64'd12);
      send_report(mac_pool[2], 32'hFFFF_FFFF, '1, 8'h7F, 8'hFF, '1, 16'h8000, 64'd13);
      send_report(mac_pool[2], 32'd0, '0, 8'h80, 8'h00, '0, 16'd100, 64'd14);
      send_report(mac_pool[1], 32'd1, '1, 8'h55, 8'hAA, 48'h5555_5555_5555, 16'h5555, '0);
      send_report(mac_pool[0], 32'hFFFF_FFFF, 64'd3, 8'hAA, 8'h55, 48'hAAAA_AAAA_AAAA,
                  16'hAAAA, '1);
      send_report(mac_pool[0], 32'h8000_0000, 64'd4, 8'h01, 8'h02, '1, 16'd2, 64'd20);
      send_report(mac_pool[1], 32'd2, 64'd5, 8'hFE, 8'h03, '0, 16'd3, 64'd21);
      send_report(mac_pool[1], 32'd100, 64'd6, 8'h10, 8'h04, '1, 16'd4, 64'd22);

      // Random: mostly rising sequences per source, then a wider pool that fills the table
      for (int n = 0; n < 850; n++) begin
         if (n == 300) drain();
         source_idle_on = (n < 400) || (n >= 500 && n < 700);
         sink_idle_on   = source_idle_on;
         pool_used      = (n < 250) ? 24 : POOL_SIZE;
         local_ms       = local_ms + pksl_pkg::TIME_W'($urandom_range(1, 1000));
         now            = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : local_ms;
         if (n >= 250 && $urandom_range(0, 9) == 0) begin
            wide = {$urandom, $urandom};
            mac  = wide[pksl_pkg::MAC_W-1:0];
            seq  = $urandom;
         end else begin
            k   = $urandom_range(0, pool_used - 1);
            mac = mac_pool[k];
            case ($urandom_range(0, 9))
               0: seq = '0;
               1: seq = $urandom;
               2: seq = next_seq[k] - $urandom_range(1, 4);
               default: seq = next_seq[k] +
                  (($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : 0);
            endcase
            next_seq[k] = seq + pksl_pkg::SEQ_W'(1);
         end
         send_report(mac, seq, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                     pksl_pkg::MAC_W'({$urandom, $urandom}), 16'($urandom), now);
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("per_source_keepalive_loss_stats verification clean");
      else
         $display("per_source_keepalive_loss_stats verification failed");
      $finish;
   end

endmodule
